// File: src/sfr_pkg.sv
// shared types and constants for the sync frame receiver
// no dependencies
package sfr_pkg;
  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_ACCEPT = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_TAIL_FIRST  = 2'd2;
  localparam logic [1:0] REG_TAIL_SECOND = 2'd3;
  localparam int CHECK_POS_NOMINAL = 130;
  localparam int RESYNC_START = 2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic [7:0] read_index;
  } cmd_t;
endpackage

// File: src/sfr_ram.sv
// generic single-port-write, one-read ram with registered read data
// no dependencies
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 133
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/sfr_front.sv
// front end: input skid and two-entry command queue toward the engine
// depends on sfr_pkg
module sfr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  sfr_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_pop,
  output sfr_pkg::cmd_t q_cmd
);
  import sfr_pkg::*;
  cmd_t       ent_r [2];
  logic [1:0] cnt_r;
  logic       rd_r;
  logic       push;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_cmd     = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
      if (q_pop) begin
        rd_r <= ~rd_r;
      end
    end
    if (push) begin
      ent_r[rd_r ^ cnt_r[0]] <= in_cmd;
    end
  end
endmodule

// File: src/sfr_engine.sv
// back end: sequencer over work and held buffers, checksum and resync walks
// depends on sfr_pkg and sfr_ram
module sfr_engine #(
  parameter int FRAME_BYTES = 133
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_pop,
  input  sfr_pkg::cmd_t q_cmd,
  input  logic [7:0]    sync_first,
  input  logic [7:0]    sync_second,
  input  logic [7:0]    tail_first,
  input  logic [7:0]    tail_second,
  output logic          res_valid,
  input  logic          res_ready,
  output logic [1:0]    res_status,
  output logic [7:0]    res_read_data,
  output logic          res_held,
  output logic [7:0]    res_fill
);
  import sfr_pkg::*;
  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CP = (CHECK_POS_NOMINAL < FRAME_BYTES - 2) ? CHECK_POS_NOMINAL
                                                             : FRAME_BYTES - 3;
  localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_CHK = 3'd2,
                         S_SCAN = 3'd3, S_MOVE = 3'd4, S_COPY = 3'd5,
                         S_OUT = 3'd6;

  logic [2:0]  state_r;
  logic [7:0]  count_r;
  logic        held_r;
  logic [7:0]  ptr_r;      // walk read address
  logic [7:0]  dst_r;      // write address for move and copy
  logic [7:0]  src_r;      // resync start position
  logic [7:0]  xor_r;
  logic        ok_r;
  logic        rvalid_r;   // ram data at ptr of last cycle is present
  logic [7:0]  rptr_r;
  logic [1:0]  ostat_r;
  logic [7:0]  ord_r;
  logic [7:0]  rdidx_r;

  logic          wwe, hwe;
  logic [AW-1:0] wwa, wra, hra;
  logic [7:0]    wwd, wrd, hrd;

  sfr_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_work (
    .clk, .we(wwe), .waddr(wwa), .wdata(wwd), .raddr(wra), .rdata(wrd));
  sfr_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_held (
    .clk, .we(hwe), .waddr(wwa), .wdata(wrd), .raddr(hra), .rdata(hrd));

  logic [7:0] last;
  assign last = 8'(FRAME_BYTES - 1);

  always_comb begin
    q_pop = 1'b0;
    wwe = 1'b0; hwe = 1'b0;
    wwa = count_r[AW-1:0];
    wwd = q_cmd.data_byte;
    wra = ptr_r[AW-1:0];
    hra = rdidx_r[AW-1:0];
    if (state_r == S_IDLE && q_valid) begin
      q_pop = 1'b1;
      if (q_cmd.action == ACT_PUSH) begin
        if (count_r == 8'd0) wwe = (q_cmd.data_byte == sync_first);
        else if (count_r == 8'd1) begin
          wwe = 1'b1;
          wwa = (q_cmd.data_byte == sync_second) ? AW'(1) : AW'(0);
        end else if (count_r < 8'(FRAME_BYTES)) wwe = 1'b1;
      end
    end
    if (state_r == S_MOVE && rvalid_r) begin
      wwe = 1'b1; wwa = dst_r[AW-1:0]; wwd = wrd;
    end
    if (state_r == S_COPY && rvalid_r) begin
      hwe = 1'b1; wwa = dst_r[AW-1:0];
    end
  end

  assign res_valid     = (state_r == S_OUT);
  assign res_status    = ostat_r;
  assign res_read_data = ord_r;
  assign res_held      = held_r;
  assign res_fill      = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= 8'd0;
      held_r  <= 1'b0;
      rvalid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (q_valid) begin
          ostat_r <= ST_NONE;
          ord_r   <= 8'd0;
          rdidx_r <= q_cmd.read_index;
          state_r <= S_OUT;
          case (q_cmd.action)
            ACT_PUSH: begin
              if (count_r == 8'd0) begin
                if (q_cmd.data_byte == sync_first) count_r <= 8'd1;
              end else if (count_r == 8'd1) begin
                if (q_cmd.data_byte == sync_second) count_r <= 8'd2;
                else count_r <= (q_cmd.data_byte == sync_first) ? 8'd1 : 8'd0;
              end else if (count_r >= 8'(FRAME_BYTES)) begin
                count_r <= 8'd0;
              end else begin
                count_r <= count_r + 8'd1;
                if (count_r == last) begin
                  state_r <= S_CHK;
                  ptr_r <= 8'd0; xor_r <= 8'd0; ok_r <= 1'b1;
                  rvalid_r <= 1'b0;
                end
              end
            end
            ACT_READ: if (held_r && q_cmd.read_index < 8'(FRAME_BYTES))
              state_r <= S_READ;
            ACT_CLEAR: begin count_r <= 8'd0; held_r <= 1'b0; end
            default: ;
          endcase
        end
        S_READ: begin
          // held ram read issued last cycle
          if (rvalid_r) begin
            ord_r <= hrd; rvalid_r <= 1'b0; state_r <= S_OUT;
          end else rvalid_r <= 1'b1;
        end
        S_CHK: begin
          rptr_r <= ptr_r;
          rvalid_r <= (ptr_r < 8'(FRAME_BYTES));
          if (ptr_r < 8'(FRAME_BYTES)) ptr_r <= ptr_r + 8'd1;
          if (rvalid_r) begin
            if (rptr_r == 8'd0 && wrd != sync_first) ok_r <= 1'b0;
            if (rptr_r == 8'd1 && wrd != sync_second) ok_r <= 1'b0;
            if (rptr_r == 8'(FRAME_BYTES - 2) && wrd != tail_first) ok_r <= 1'b0;
            if (rptr_r == last && wrd != tail_second) ok_r <= 1'b0;
            if (rptr_r < 8'(CP)) xor_r <= xor_r ^ wrd;
            if (rptr_r == 8'(CP) && wrd != xor_r) ok_r <= 1'b0;
            if (rptr_r == last) begin
              rvalid_r <= 1'b0;
              if (ok_r && !(wrd != tail_second)) begin
                state_r <= S_COPY; ptr_r <= 8'd0; dst_r <= 8'd0;
              end else begin
                state_r <= S_SCAN; ptr_r <= 8'(RESYNC_START);
              end
            end
          end
        end
        S_SCAN: begin
          rptr_r <= ptr_r;
          rvalid_r <= 1'b1;
          if (ptr_r < 8'(FRAME_BYTES)) ptr_r <= ptr_r + 8'd1;
          if (rvalid_r) begin
            if (wrd == sync_first) begin
              src_r <= rptr_r; ptr_r <= rptr_r; dst_r <= 8'd0;
              rvalid_r <= 1'b0; state_r <= S_MOVE;
            end else if (rptr_r == last) begin
              rvalid_r <= 1'b0; count_r <= 8'd0;
              ostat_r <= ST_REJECT; state_r <= S_OUT;
            end
          end
        end
        S_MOVE: begin
          rvalid_r <= (ptr_r < 8'(FRAME_BYTES));
          if (ptr_r < 8'(FRAME_BYTES)) ptr_r <= ptr_r + 8'd1;
          if (rvalid_r) begin
            dst_r <= dst_r + 8'd1;
            if (dst_r == last - src_r) begin
              rvalid_r <= 1'b0;
              count_r <= 8'(FRAME_BYTES) - src_r;
              ostat_r <= ST_REJECT; state_r <= S_OUT;
            end
          end
        end
        S_COPY: begin
          rvalid_r <= (ptr_r < 8'(FRAME_BYTES));
          if (ptr_r < 8'(FRAME_BYTES)) ptr_r <= ptr_r + 8'd1;
          if (rvalid_r) begin
            dst_r <= dst_r + 8'd1;
            if (dst_r == last) begin
              rvalid_r <= 1'b0; held_r <= 1'b1; count_r <= 8'd0;
              ostat_r <= ST_ACCEPT; state_r <= S_OUT;
            end
          end
        end
        S_OUT: if (res_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: src/sync_frame_receiver_xor_check.sv
// top level of the fixed-length sync frame receiver with xor check
// depends on sfr_pkg, sfr_front, sfr_engine, sfr_ram
//
// in channel: one transfer per action (push byte, read held byte, clear).
// out channel: exactly one result transfer per input transfer, in order.
// a push or read that does not end a frame goes from decode to result; a read
// of a held byte first waits in a read state for the registered held ram read.
// the push that completes a frame walks the work ram once for the header,
// tail and xor check, then either copies the frame into the held ram or
// scans for a new sync byte and slides the tail down, emptying the buffer
// if none is found. these walks through the single-read work ram set the
// frame-end cost; the engine takes its next command only once the result
// of the last one has been taken.
// a two-entry queue keeps taking input, until full, while the engine works or
// while out_tready is low; the engine holds its result until out_tready.
// reset: empty buffer, no frame held, registers to their default values.
// config writes apply at once and should happen only while idle.
module sync_frame_receiver_xor_check #(
  parameter int FRAME_BYTES = 133
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // action
  input  logic [15:0] in_tdata,   // data_byte[7:0], read_index[15:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // frame_status[1:0], read_data[9:2],
                                  // frame_held[10], fill_level[18:11], zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import sfr_pkg::*;
  logic [7:0] sync_first_r, sync_second_r, tail_first_r, tail_second_r;
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;
  logic [1:0] st;
  logic [7:0] rd, fill;
  logic held;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= 8'd252;
      sync_second_r <= 8'd207;
      tail_first_r  <= 8'd253;
      tail_second_r <= 8'd223;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_FIRST:  sync_first_r  <= cfg_data;
        REG_SYNC_SECOND: sync_second_r <= cfg_data;
        REG_TAIL_FIRST:  tail_first_r  <= cfg_data;
        REG_TAIL_SECOND: tail_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_cmd = '{action: in_tuser, data_byte: in_tdata[7:0],
                    read_index: in_tdata[15:8]};

  sfr_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_cmd,
    .q_valid, .q_pop, .q_cmd);

  sfr_engine #(.FRAME_BYTES(FRAME_BYTES)) u_engine (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd,
    .sync_first(sync_first_r), .sync_second(sync_second_r),
    .tail_first(tail_first_r), .tail_second(tail_second_r),
    .res_valid(out_tvalid), .res_ready(out_tready),
    .res_status(st), .res_read_data(rd), .res_held(held), .res_fill(fill));

  assign out_tdata = {5'd0, fill, held, rd, st};

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= 8'(FRAME_BYTES)) else $error("fill level past frame size");
  a_accept_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_ACCEPT |-> held && fill == 8'd0)
    else $error("accepted frame not held");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (st == ST_NONE || st == ST_ACCEPT || st == ST_REJECT))
    else $error("bad status");
endmodule
